// ===== rtl/core/ktlt_pkg.sv =====
// Package for the keyed total leader tracker.
// Holds table sizing, request and status codes, and the structs shared by the modules.
`default_nettype none

package ktlt_pkg;

  localparam int TABLE_ENTRIES = 64;
  localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W         = IDX_W + 1;
  localparam int KEY_W         = 31;
  localparam int TOT_W         = 32;
  localparam int ENTRY_W       = KEY_W + TOT_W;

  localparam logic signed [TOT_W-1:0] BEST_START = -32'sd100;

  typedef enum logic [1:0] {
    REQ_ADD   = 2'd0,
    REQ_QUERY = 2'd1
  } req_e;

  typedef enum logic [1:0] {
    STATUS_LEADER  = 2'd0,
    STATUS_NODATA  = 2'd1,
    STATUS_INVALID = 2'd2,
    STATUS_FULL    = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_ADD,
    S_WRITE,
    S_FULL
  } ctrl_state_e;

  // Total update offered to the leader tracker
  typedef struct packed {
    logic                    valid;
    logic [KEY_W-1:0]        key;
    logic signed [TOT_W-1:0] total;
  } upd_t;

  // Current leader as seen by the controller
  typedef struct packed {
    logic             valid;
    logic [KEY_W-1:0] key;
  } ldr_t;

  // One result toward the output register
  typedef struct packed {
    logic             valid;
    status_e          status;
    logic [KEY_W-1:0] key;
  } res_t;

endpackage

`default_nettype wire

// ===== rtl/core/ktlt_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module ktlt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                      clk_i,
  input  wire logic                                      we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                          wdata_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                          rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ===== rtl/core/ktlt_leader.sv =====
// Leader register: best total, its key and a valid flag.
// Depends on ktlt_pkg.
`default_nettype none

module ktlt_leader (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire ktlt_pkg::upd_t upd_i,
  output ktlt_pkg::ldr_t      ldr_o
);
  import ktlt_pkg::*;

  logic signed [TOT_W-1:0] best_total_q, best_total_d;
  logic [KEY_W-1:0]        best_key_q, best_key_d;
  logic                    valid_q, valid_d;

  always_comb begin
    best_total_d = best_total_q;
    best_key_d   = best_key_q;
    valid_d      = valid_q;
    // take over only on a strictly greater total
    if (upd_i.valid && (upd_i.total > best_total_q)) begin
      best_total_d = upd_i.total;
      best_key_d   = upd_i.key;
      valid_d      = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_total_q <= BEST_START;
      best_key_q   <= '0;
      valid_q      <= 1'b0;
    end else begin
      best_total_q <= best_total_d;
      best_key_q   <= best_key_d;
      valid_q      <= valid_d;
    end
  end

  assign ldr_o.valid = valid_q;
  assign ldr_o.key   = best_key_q;

endmodule

`default_nettype wire

// ===== rtl/core/ktlt_ctrl.sv =====
// Request sequencer: answers queries from the leader, linear key search over the entry RAM, saturating add, write back.
// Depends on ktlt_pkg and ktlt_ram.
`default_nettype none

module ktlt_ctrl (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic [1:0]                     req_type_i,
  input  wire logic [ktlt_pkg::KEY_W-1:0]     entry_key_i,
  input  wire logic signed [ktlt_pkg::TOT_W-1:0] amount_i,
  input  wire logic                           slot_free_i,
  input  wire ktlt_pkg::ldr_t                 ldr_i,
  output ktlt_pkg::upd_t                      upd_o,
  output ktlt_pkg::res_t                      res_o
);
  import ktlt_pkg::*;

  function automatic logic signed [TOT_W-1:0] sat_add(
    input logic signed [TOT_W-1:0] a,
    input logic signed [TOT_W-1:0] b
  );
    logic signed [TOT_W:0] s;
    logic signed [TOT_W-1:0] r;
    s = {a[TOT_W-1], a} + {b[TOT_W-1], b};
    if (s[TOT_W] != s[TOT_W-1]) begin
      r = s[TOT_W] ? {1'b1, {(TOT_W-1){1'b0}}} : {1'b0, {(TOT_W-1){1'b1}}};
    end else begin
      r = s[TOT_W-1:0];
    end
    return r;
  endfunction

  ctrl_state_e             state_q, state_d;
  logic [KEY_W-1:0]        key_q, key_d;
  logic signed [TOT_W-1:0] amt_q, amt_d;
  logic signed [TOT_W-1:0] tot_q, tot_d;
  logic [IDX_W-1:0]        rd_idx_q, rd_idx_d;
  logic [IDX_W-1:0]        slot_q, slot_d;
  logic                    is_new_q, is_new_d;
  logic [CNT_W-1:0]        used_q, used_d;

  logic [CNT_W-1:0]        nxt_idx;
  logic [IDX_W-1:0]        raddr;
  logic                    we;
  logic [ENTRY_W-1:0]      rdata;
  logic [KEY_W-1:0]        rd_key;
  logic signed [TOT_W-1:0] rd_tot;
  logic                    take;

  assign nxt_idx = {1'b0, rd_idx_q} + CNT_W'(1);
  // probe entry zero while idle, the next entry while searching
  assign raddr   = (state_q == S_IDLE) ? '0 : nxt_idx[IDX_W-1:0];
  assign rd_key  = rdata[ENTRY_W-1:TOT_W];
  assign rd_tot  = rdata[TOT_W-1:0];

  ktlt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (slot_q),
    .wdata_i ({key_q, tot_q}),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign in_stall_o = !((state_q == S_IDLE) && slot_free_i);
  assign take       = in_valid_i && !in_stall_o;

  always_comb begin
    state_d   = state_q;
    key_d     = key_q;
    amt_d     = amt_q;
    tot_d     = tot_q;
    rd_idx_d  = rd_idx_q;
    slot_d    = slot_q;
    is_new_d  = is_new_q;
    used_d    = used_q;
    we        = 1'b0;
    upd_o     = '0;
    res_o     = '0;

    case (state_q)
      S_IDLE: begin
        if (take) begin
          key_d = entry_key_i;
          amt_d = amount_i;
          case (req_type_i)
            REQ_ADD: begin
              if (entry_key_i == '0) begin
                res_o.valid  = 1'b1;
                res_o.status = STATUS_INVALID;
              end else if (used_q == '0) begin
                slot_d   = '0;
                tot_d    = '0;
                is_new_d = 1'b1;
                state_d  = S_ADD;
              end else begin
                rd_idx_d = '0;
                state_d  = S_SEARCH;
              end
            end
            REQ_QUERY: begin
              res_o.valid  = 1'b1;
              res_o.status = ldr_i.valid ? STATUS_LEADER : STATUS_NODATA;
              res_o.key    = ldr_i.valid ? ldr_i.key : '0;
            end
            default: begin
              res_o.valid  = 1'b1;
              res_o.status = STATUS_INVALID;
            end
          endcase
        end
      end
      S_SEARCH: begin
        if (rd_key == key_q) begin
          slot_d   = rd_idx_q;
          tot_d    = rd_tot;
          is_new_d = 1'b0;
          state_d  = S_ADD;
        end else if (nxt_idx < used_q) begin
          rd_idx_d = nxt_idx[IDX_W-1:0];
        end else if (used_q == CNT_W'(TABLE_ENTRIES)) begin
          state_d = S_FULL;
        end else begin
          // append new key with a zero total
          slot_d   = used_q[IDX_W-1:0];
          tot_d    = '0;
          is_new_d = 1'b1;
          state_d  = S_ADD;
        end
      end
      S_ADD: begin
        tot_d   = sat_add(tot_q, amt_q);
        state_d = S_WRITE;
      end
      S_WRITE: begin
        we          = 1'b1;
        upd_o.valid = 1'b1;
        upd_o.key   = key_q;
        upd_o.total = tot_q;
        if (is_new_q) begin
          used_d = used_q + CNT_W'(1);
        end
        state_d = S_IDLE;
      end
      S_FULL: begin
        // hold until the output register can take the drop report
        if (slot_free_i) begin
          res_o.valid  = 1'b1;
          res_o.status = STATUS_FULL;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      used_q  <= '0;
    end else begin
      state_q <= state_d;
      used_q  <= used_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q    <= key_d;
    amt_q    <= amt_d;
    tot_q    <= tot_d;
    rd_idx_q <= rd_idx_d;
    slot_q   <= slot_d;
    is_new_q <= is_new_d;
  end

endmodule

`default_nettype wire

// ===== rtl/core/keyed_total_leader_tracker_top.sv =====
// Results: a query or invalid request is answered in the cycle after the transfer; an add gives no
// result unless the table is full, and steps through search (skipped on an empty table, one RAM
// probe a cycle), add and write. One request at a time: the linear key search over the entry RAM
// holds further requests off until an add is done; a query takes no further state.
// Reset: asynchronous, active low; clears fill count, leader and output valid, RAM left as is.
// Depends on ktlt_pkg, ktlt_ctrl, ktlt_leader, ktlt_ram.
`default_nettype none

module keyed_total_leader_tracker_top (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic [1:0]                        req_type_i,
  input  wire logic [ktlt_pkg::KEY_W-1:0]        entry_key_i,
  input  wire logic signed [ktlt_pkg::TOT_W-1:0] amount_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic [1:0]                             status_o,
  output logic [ktlt_pkg::KEY_W-1:0]             leader_key_o
);
  import ktlt_pkg::*;

  upd_t             upd;
  ldr_t             ldr;
  res_t             res;
  logic             slot_free;
  logic             out_valid_q, out_valid_d;
  status_e          status_q, status_d;
  logic [KEY_W-1:0] key_q, key_d;

  assign slot_free = !out_valid_q || !out_stall_i;

  ktlt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .req_type_i  (req_type_i),
    .entry_key_i (entry_key_i),
    .amount_i    (amount_i),
    .slot_free_i (slot_free),
    .ldr_i       (ldr),
    .upd_o       (upd),
    .res_o       (res)
  );

  ktlt_leader u_leader (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .upd_i  (upd),
    .ldr_o  (ldr)
  );

  // output register: load on a new result, drop after the transfer
  always_comb begin
    out_valid_d = out_valid_q;
    status_d    = status_q;
    key_d       = key_q;
    if (res.valid) begin
      out_valid_d = 1'b1;
      status_d    = res.status;
      key_d       = res.key;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    key_q    <= key_d;
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign leader_key_o = key_q;

endmodule

`default_nettype wire

// ===== rtl/core/ktlt_checker.sv =====
// Port-level checks for the keyed total leader tracker, bound to the top level.
// Depends on ktlt_pkg.
`default_nettype none

module ktlt_checker (
  input wire logic                              clk_i,
  input wire logic                              rst_ni,
  input wire logic                              in_valid_i,
  input wire logic                              in_stall_o,
  input wire logic [1:0]                        req_type_i,
  input wire logic [ktlt_pkg::KEY_W-1:0]        entry_key_i,
  input wire logic                              out_valid_o,
  input wire logic                              out_stall_i,
  input wire logic [1:0]                        status_o,
  input wire logic [ktlt_pkg::KEY_W-1:0]        leader_key_o
);
  import ktlt_pkg::*;

  logic in_xfer;
  assign in_xfer = in_valid_i && !in_stall_o;

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // a leader report carries a positive key, anything else carries zero
  a_key_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((status_o == STATUS_LEADER) ? (leader_key_o != '0)
                                                 : (leader_key_o == '0)))
    else $error("leader key does not match status");

  // a query answers in the next cycle with leader or no data
  a_query_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && (req_type_i == REQ_QUERY) |=>
      out_valid_o && ((status_o == STATUS_LEADER) || (status_o == STATUS_NODATA)))
    else $error("query not answered");

  // unknown request types and zero keys are refused at once
  a_invalid_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && (((req_type_i != REQ_ADD) && (req_type_i != REQ_QUERY)) ||
                ((req_type_i == REQ_ADD) && (entry_key_i == '0))) |=>
      out_valid_o && (status_o == STATUS_INVALID))
    else $error("invalid request not reported");

endmodule

bind keyed_total_leader_tracker_top ktlt_checker u_ktlt_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .req_type_i   (req_type_i),
  .entry_key_i  (entry_key_i),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .status_o     (status_o),
  .leader_key_o (leader_key_o)
);

`default_nettype wire
